/* sv/mi3_pkg.sv */
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int N_ELEM        = 9;
    localparam int N_PROD        = 18;
    localparam int N_DET         = 3;
    localparam int CO_W          = 64;               // exact cofactor
    localparam int PL_W          = ELEM_W + 33;      // element times low cofactor half
    localparam int DET_W         = 98;               // exact determinant, signed
    localparam int QBITS         = 33;               // quotient bits kept before saturation
    localparam int REM_W         = DET_W + QBITS + 1;
    localparam int N_FRONT       = 7;                // stages up to the divider input
    localparam int N_STG         = N_FRONT + QBITS + 2;

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [CO_W-1:0]   t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic [REM_W-1:0]         t_rem;
    typedef logic [QBITS-1:0]         t_quo;

    // Element k of the matrix is row k%3, column k/3.
    // Cofactor k = elem[PROD_A[2k]]*elem[PROD_B[2k]] - elem[PROD_A[2k+1]]*elem[PROD_B[2k+1]],
    // already placed at the transposed (adjugate) position.
    localparam logic [3:0] PROD_A [N_PROD] = '{
        4'd4, 4'd5, 4'd7, 4'd1, 4'd1, 4'd2, 4'd6, 4'd3, 4'd0,
        4'd6, 4'd2, 4'd0, 4'd3, 4'd6, 4'd1, 4'd0, 4'd0, 4'd1
    };
    localparam logic [3:0] PROD_B [N_PROD] = '{
        4'd8, 4'd7, 4'd2, 4'd8, 4'd5, 4'd4, 4'd5, 4'd8, 4'd8,
        4'd2, 4'd3, 4'd5, 4'd7, 4'd4, 4'd6, 4'd7, 4'd4, 4'd3
    };

    // First-row expansion: det = sum of elem[DET_E[j]] * cofactor j
    localparam logic [3:0] DET_E [N_DET] = '{4'd0, 4'd3, 4'd6};

endpackage

/* sv/matrix_inverse_3x3_core.sv */
`timescale 1ns / 1ps

// 3x3 matrix inverse by adjugate, signed fixed point with FRAC_BITS fraction bits.
// Input channel: i_valid / o_stall carry one matrix request (nine elements) per
// accepted edge; output channel: o_valid / i_stall carry nine inverse elements
// plus o_singular. A request is accepted when valid is high and stall is low.
// Throughput: one matrix per cycle, sustained, with no gaps between requests, while i_stall stays low.
// Pipeline of 42 register stages: input capture, products, cofactors,
// determinant partial products, terms, sum, magnitude prep, an overflow
// check, 33 restoring divide steps (one quotient bit each, nine lanes side
// by side) and the output register.
// A zero determinant sends the input elements through unchanged with
// o_singular high; otherwise each quotient is truncated toward zero and
// saturated to the 32-bit range.
// Reset (synchronous, active low) empties the pipeline; results in flight are dropped.
// When the receiver stalls, the output holds and stages fill up behind it;
// bubbles still close up, and o_stall rises only once every stage is full.
module matrix_inverse_3x3_core
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF     // 8 .. 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [ELEM_W-1:0] i_in_r0c0,
    input  logic signed [ELEM_W-1:0] i_in_r1c0,
    input  logic signed [ELEM_W-1:0] i_in_r2c0,
    input  logic signed [ELEM_W-1:0] i_in_r0c1,
    input  logic signed [ELEM_W-1:0] i_in_r1c1,
    input  logic signed [ELEM_W-1:0] i_in_r2c1,
    input  logic signed [ELEM_W-1:0] i_in_r0c2,
    input  logic signed [ELEM_W-1:0] i_in_r1c2,
    input  logic signed [ELEM_W-1:0] i_in_r2c2,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [ELEM_W-1:0] o_out_r0c0,
    output logic signed [ELEM_W-1:0] o_out_r1c0,
    output logic signed [ELEM_W-1:0] o_out_r2c0,
    output logic signed [ELEM_W-1:0] o_out_r0c1,
    output logic signed [ELEM_W-1:0] o_out_r1c1,
    output logic signed [ELEM_W-1:0] o_out_r2c1,
    output logic signed [ELEM_W-1:0] o_out_r0c2,
    output logic signed [ELEM_W-1:0] o_out_r1c2,
    output logic signed [ELEM_W-1:0] o_out_r2c2,
    output logic        o_singular
);

    localparam int D0  = N_FRONT;       // valid index of the overflow check stage
    localparam int LST = N_STG - 1;     // valid index of the output register

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_adv;
    logic [N_STG-1:0] w_vin;

    always_comb begin
        w_adv[LST] = !r_vld[LST] || !i_stall;
        for (int k = LST - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        w_vin[0] = i_valid;
        for (int k = 1; k < N_STG; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[LST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the request
    // ------------------------------------------------------------------
    t_elem w_in [N_ELEM];
    assign w_in[0] = i_in_r0c0;
    assign w_in[1] = i_in_r1c0;
    assign w_in[2] = i_in_r2c0;
    assign w_in[3] = i_in_r0c1;
    assign w_in[4] = i_in_r1c1;
    assign w_in[5] = i_in_r2c1;
    assign w_in[6] = i_in_r0c2;
    assign w_in[7] = i_in_r1c2;
    assign w_in[8] = i_in_r2c2;

    t_elem r1_m [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_m <= w_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: eighteen 32x32 products for the cofactors
    // ------------------------------------------------------------------
    t_cof  r2_p [N_PROD];
    t_elem r2_m [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int k = 0; k < N_PROD; k++) begin
                r2_p[k] <= r1_m[PROD_A[k]] * r1_m[PROD_B[k]];
            end
            r2_m <= r1_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cofactors (fit 64 bits signed exactly)
    // ------------------------------------------------------------------
    t_cof  r3_c [N_ELEM];
    t_elem r3_m [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r3_c[k] <= r2_p[2*k] - r2_p[2*k+1];
            end
            r3_m <= r2_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: element times cofactor, split into two 32-bit halves
    // ------------------------------------------------------------------
    logic signed [PL_W-1:0] r4_pl [N_DET];
    t_cof                   r4_ph [N_DET];
    t_cof                   r4_c  [N_ELEM];
    t_elem                  r4_m  [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int j = 0; j < N_DET; j++) begin
                r4_pl[j] <= r3_m[DET_E[j]] * $signed({1'b0, r3_c[j][31:0]});
                r4_ph[j] <= r3_m[DET_E[j]] * $signed(r3_c[j][63:32]);
            end
            r4_c <= r3_c;
            r4_m <= r3_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine halves into full terms
    // ------------------------------------------------------------------
    t_det  r5_t [N_DET];
    t_cof  r5_c [N_ELEM];
    t_elem r5_m [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int j = 0; j < N_DET; j++) begin
                r5_t[j] <= (DET_W'(r4_ph[j]) <<< 32) + DET_W'(r4_pl[j]);
            end
            r5_c <= r4_c;
            r5_m <= r4_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: determinant
    // ------------------------------------------------------------------
    t_det  r6_det;
    t_cof  r6_c [N_ELEM];
    t_elem r6_m [N_ELEM];
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_det <= r5_t[0] + r5_t[1] + r5_t[2];
            r6_c   <= r5_c;
            r6_m   <= r5_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: magnitudes, quotient sign, scaled numerators. A singular
    // matrix preloads the quotient with the input element and freezes it.
    // ------------------------------------------------------------------
    t_rem               r7_rem [N_ELEM];
    t_quo               r7_q   [N_ELEM];
    logic [N_ELEM-1:0]  r7_neg;
    logic [DET_W-1:0]   r7_dm;
    logic               r7_sing;

    logic               w6_sing;
    logic [CO_W-1:0]    w6_cm [N_ELEM];
    always_comb begin
        w6_sing = (r6_det == '0);
        for (int k = 0; k < N_ELEM; k++) begin
            w6_cm[k] = r6_c[k][CO_W-1] ? CO_W'(-r6_c[k]) : CO_W'(r6_c[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_dm   <= r6_det[DET_W-1] ? DET_W'(-r6_det) : DET_W'(r6_det);
            r7_sing <= w6_sing;
            for (int k = 0; k < N_ELEM; k++) begin
                r7_rem[k] <= REM_W'(w6_cm[k]) << (2 * FRAC_BITS);
                r7_neg[k] <= r6_c[k][CO_W-1] ^ r6_det[DET_W-1];
                r7_q[k]   <= w6_sing ? {1'b0, r6_m[k]} : '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: entry 0 flags quotients of 2^33 or more; entries 1..QBITS
    // each resolve one quotient bit, MSB first, in all nine lanes.
    // ------------------------------------------------------------------
    t_rem              r_drem [QBITS+1][N_ELEM];
    t_quo              r_dq   [QBITS+1][N_ELEM];
    logic [N_ELEM-1:0] r_dneg [QBITS+1];
    logic [N_ELEM-1:0] r_dovf [QBITS+1];
    logic [DET_W-1:0]  r_ddm  [QBITS+1];
    logic              r_dsing [QBITS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv[D0]) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_dovf[0][k] <= r7_rem[k] >= (REM_W'(r7_dm) << QBITS);
            end
            r_drem[0]  <= r7_rem;
            r_dq[0]    <= r7_q;
            r_dneg[0]  <= r7_neg;
            r_ddm[0]   <= r7_dm;
            r_dsing[0] <= r7_sing;
        end
    end

    for (genvar gd = 0; gd < QBITS; gd++) begin : g_step
        localparam int WT = QBITS - 1 - gd;

        logic [REM_W:0] w_diff [N_ELEM];
        t_rem           w_sub;
        assign w_sub = REM_W'(r_ddm[gd]) << WT;

        always_comb begin
            for (int k = 0; k < N_ELEM; k++) begin
                w_diff[k] = {1'b0, r_drem[gd][k]} - {1'b0, w_sub};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[D0+gd+1]) begin
                for (int k = 0; k < N_ELEM; k++) begin
                    // keep the trial difference when it does not borrow and the matrix is not singular
                    if (!w_diff[k][REM_W] && !r_dsing[gd]) begin
                        r_drem[gd+1][k]     <= w_diff[k][REM_W-1:0];
                        r_dq[gd+1][k]       <= r_dq[gd][k] | (t_quo'(1) << WT);
                    end else begin
                        r_drem[gd+1][k]     <= r_drem[gd][k];
                        r_dq[gd+1][k]       <= r_dq[gd][k];
                    end
                end
                r_dneg[gd+1]  <= r_dneg[gd];
                r_dovf[gd+1]  <= r_dovf[gd];
                r_ddm[gd+1]   <= r_ddm[gd];
                r_dsing[gd+1] <= r_dsing[gd];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: sign, saturate, or pass the singular input through
    // ------------------------------------------------------------------
    t_elem r_out [N_ELEM];
    logic  r_sing;
    t_elem w_res [N_ELEM];

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            if (r_dsing[QBITS]) begin
                w_res[k] = r_dq[QBITS][k][ELEM_W-1:0];
            end else if (r_dneg[QBITS][k]) begin
                if (r_dovf[QBITS][k] || r_dq[QBITS][k] > {1'b0, SAT_NEG}) begin
                    w_res[k] = SAT_NEG;
                end else begin
                    w_res[k] = -r_dq[QBITS][k][ELEM_W-1:0];
                end
            end else begin
                if (r_dovf[QBITS][k] || r_dq[QBITS][k] > {1'b0, SAT_POS}) begin
                    w_res[k] = SAT_POS;
                end else begin
                    w_res[k] = r_dq[QBITS][k][ELEM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[LST]) begin
            r_out  <= w_res;
            r_sing <= r_dsing[QBITS];
        end
    end

    assign o_out_r0c0 = r_out[0];
    assign o_out_r1c0 = r_out[1];
    assign o_out_r2c0 = r_out[2];
    assign o_out_r0c1 = r_out[3];
    assign o_out_r1c1 = r_out[4];
    assign o_out_r2c1 = r_out[5];
    assign o_out_r0c2 = r_out[6];
    assign o_out_r1c2 = r_out[7];
    assign o_out_r2c2 = r_out[8];
    assign o_singular = r_sing;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Backpressure on the input only comes from a stalled, full output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output");

    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // Restoring division ends with the remainder below the divisor (checked on lane 0).
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LST-1] && !r_dsing[QBITS] && !r_dovf[QBITS][0])
            |-> (r_drem[QBITS][0] < REM_W'(r_ddm[QBITS])))
        else $error("divider remainder not reduced");

endmodule

/* tb/mi3_checker.sv */
`timescale 1ns / 1ps

module mi3_checker
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_o_stall,
    input  logic [8:0][ELEM_W-1:0] i_mat,
    input  logic                   i_o_valid,
    input  logic                   i_stall,
    input  logic [8:0][ELEM_W-1:0] i_inv,
    input  logic                   i_singular,
    output int                     o_fails,
    output int                     o_pending
);

    typedef struct packed {
        logic [8:0][ELEM_W-1:0] inv;
        logic                   singular;
    } t_inverse;

    t_inverse inverse_q[$];

    // Divide an adjugate entry by the determinant, truncate toward zero, saturate.
    function automatic logic [ELEM_W-1:0] scaled_quotient(logic signed [127:0] cof,
                                                          logic signed [127:0] det);
        logic [159:0] num;
        logic [159:0] den;
        logic [159:0] q;
        logic         neg;
        neg = cof[127] ^ det[127];
        num = {32'b0, (cof[127] ? -cof : cof)};
        den = {32'b0, (det[127] ? -det : det)};
        num = num << (2 * FRAC_BITS);
        q   = num / den;
        if (neg) begin
            if (q > 160'h8000_0000) return SAT_NEG;
            return -q[ELEM_W-1:0];
        end
        if (q > 160'h7FFF_FFFF) return SAT_POS;
        return q[ELEM_W-1:0];
    endfunction

    function automatic t_inverse invert_matrix(logic [8:0][ELEM_W-1:0] m);
        logic signed [127:0] a [3][3];
        logic signed [127:0] adj [9];
        logic signed [127:0] det;
        t_inverse res;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                a[r][c] = {{96{m[c*3+r][ELEM_W-1]}}, m[c*3+r]};
        adj[0] = a[1][1]*a[2][2] - a[2][1]*a[1][2];
        adj[3] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
        adj[6] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        adj[1] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
        adj[4] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
        adj[7] = a[1][0]*a[0][2] - a[0][0]*a[1][2];
        adj[2] = a[1][0]*a[2][1] - a[2][0]*a[1][1];
        adj[5] = a[2][0]*a[0][1] - a[0][0]*a[2][1];
        adj[8] = a[0][0]*a[1][1] - a[1][0]*a[0][1];
        det = a[0][0]*adj[0] + a[0][1]*adj[1] + a[0][2]*adj[2];
        if (det == 0) begin
            res.inv      = m;
            res.singular = 1'b1;
        end else begin
            for (int k = 0; k < 9; k++) res.inv[k] = scaled_quotient(adj[k], det);
            res.singular = 1'b0;
        end
        return res;
    endfunction

    assign o_pending = inverse_q.size();

    always @(posedge i_clk) begin
        t_inverse want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fails <= 0;
        end else begin
            if (i_valid && !i_o_stall) inverse_q.push_back(invert_matrix(i_mat));
            if (i_o_valid && !i_stall) begin
                if (inverse_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errs = errs + 1;
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (i_inv[k] !== want.inv[k]) begin
                            $error("out_r%0dc%0d: expected %h, got %h",
                                   k % 3, k / 3, want.inv[k], i_inv[k]);
                            errs = errs + 1;
                        end
                    if (i_singular !== want.singular) begin
                        $error("singular: expected %b, got %b", want.singular, i_singular);
                        errs = errs + 1;
                    end
                end
            end
            o_fails <= o_fails + errs;
        end
    end

endmodule

/* tb/matrix_inverse_3x3_core_tb.sv */
`timescale 1ns / 1ps

module matrix_inverse_3x3_core_tb;
    import mi3_pkg::*;

    localparam int    N_RANDOM    = 2000;
    localparam int    CYCLE_LIMIT = 400000;
    localparam logic [31:0] ONE   = 32'h0001_0000;   // 1.0 in Q16.16

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [8:0][ELEM_W-1:0] mat = '0;
    logic [8:0][ELEM_W-1:0] inv;
    logic o_stall, o_valid, o_singular;
    int   fails, pending;
    int   cycles = 0;
    bit   quiet = 1'b0;      // long stretch with no idling on either side

    always #6 i_clk = ~i_clk;

    matrix_inverse_3x3_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_in_r0c0(mat[0]), .i_in_r1c0(mat[1]), .i_in_r2c0(mat[2]),
        .i_in_r0c1(mat[3]), .i_in_r1c1(mat[4]), .i_in_r2c1(mat[5]),
        .i_in_r0c2(mat[6]), .i_in_r1c2(mat[7]), .i_in_r2c2(mat[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_r0c0(inv[0]), .o_out_r1c0(inv[1]), .o_out_r2c0(inv[2]),
        .o_out_r0c1(inv[3]), .o_out_r1c1(inv[4]), .o_out_r2c1(inv[5]),
        .o_out_r0c2(inv[6]), .o_out_r1c2(inv[7]), .o_out_r2c2(inv[8]),
        .o_singular(o_singular)
    );

    mi3_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_stall(o_stall),
        .i_mat(mat), .i_o_valid(o_valid), .i_stall(i_stall), .i_inv(inv),
        .i_singular(o_singular), .o_fails(fails), .o_pending(pending)
    );

    // Receiver: stall in about 12 percent of cycles, never during the quiet stretch.
    always @(posedge i_clk)
        i_stall <= !quiet && ($urandom_range(0, 99) < 12);

    // Watchdog: end the run if the pipeline hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("matrix_inverse_3x3_core_tb: FAIL");
            $finish;
        end
    end

    // Hold the request until an edge with stall low takes it; o_stall is sampled
    // mid-cycle, where it is stable.
    task automatic send_matrix(input logic [8:0][ELEM_W-1:0] m);
        bit stalled;
        while (!quiet && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        mat     <= m;
        forever begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
            if (!stalled) break;
        end
    endtask

    function automatic logic [31:0] small_q16();
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic logic [8:0][ELEM_W-1:0] diag(logic [31:0] a, logic [31:0] b,
                                                    logic [31:0] c);
        logic [8:0][ELEM_W-1:0] m;
        m    = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    initial begin
        logic [8:0][ELEM_W-1:0] m;
        int kind;
        int src;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, scaled diagonals, truncation, saturation both ways,
        // singular cases, extreme elements, a general matrix and six random ones.
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000));
        send_matrix(diag(32'h0000_0001, ONE, ONE));
        send_matrix(diag(32'hFFFF_FFFF, ONE, ONE));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
        send_matrix('0);
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'hFFFF_FFFF}});
        send_matrix({32'h0007_0000, 32'h0002_0000, 32'h0005_0000,
                     32'h0001_0000, 32'hFFFD_0000, 32'h0004_0000,
                     32'h0002_0000, 32'h0001_0000, 32'h0003_0000});
        for (int k = 0; k < 6; k++) begin
            for (int j = 0; j < 9; j++) m[j] = $urandom();
            send_matrix(m);
        end

        // Random: mostly small well-conditioned values, plus full-range, singular
        // (repeated column) and diagonal matrices.
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 800 && n < 1100);
            kind  = $urandom_range(0, 99);
            for (int j = 0; j < 9; j++) m[j] = (kind < 30) ? $urandom() : small_q16();
            if (kind >= 55 && kind < 75) begin
                src = $urandom_range(0, 1) * 3;
                for (int r = 0; r < 3; r++) m[6 + r] = m[src + r];
            end else if (kind >= 75 && kind < 85) begin
                m = diag($urandom_range(0, 3) == 0 ? $urandom() : small_q16(),
                         small_q16(), $urandom_range(0, 3) == 0 ? $urandom() : small_q16());
            end
            send_matrix(m);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("matrix_inverse_3x3_core_tb: PASS");
        else
            $display("matrix_inverse_3x3_core_tb: FAIL");
        $finish;
    end

endmodule

/* matrix_inverse_3x3_core.f */
sv/mi3_pkg.sv
sv/matrix_inverse_3x3_core.sv
tb/mi3_checker.sv
tb/matrix_inverse_3x3_core_tb.sv
